[hdl/hsva_pkg.sv]
// Shared widths, hue sector codes and stage control types for the HSV to ARGB converter.
// Used by the channel interfaces, the channel scaler and the top level.
`default_nettype none

package hsva_pkg;

	// Field widths of one item
	localparam int HUE_W = 16;
	localparam int SAT_W = 9;
	localparam int VAL_W = 9;
	localparam int INT_W = 9;
	localparam int ARGB_W = 32;

	// Internal fixed-point widths
	localparam int FRAC_W = 16;               // hue fraction, Q0.16
	localparam int RAMP_W = FRAC_W + 1;       // 0 .. 65536
	localparam int C16_W = 18;                // value * saturation
	localparam int XX_W = 34;                 // chroma product with ramp, Q.32
	localparam int MM_W = 36;                 // signed offset, Q.32
	localparam int Q_W = 33;                  // clamped channel level, Q.32
	localparam int P_W = Q_W + INT_W;         // level * intensity
	localparam int S_W = P_W + 8;             // times 255
	localparam int SHIFT = 40;                // Q.32 * Q1.8 back to integer
	localparam int HI_W = S_W - SHIFT;        // integer part before saturation

	localparam logic [7:0] ALPHA_BYTE = 8'hFF;
	localparam logic [7:0] CHAN_MAX = 8'hFF;

	// Hue sectors of 60 degrees each
	typedef enum logic [2:0] {
		SECT_RED_YEL = 3'd0,
		SECT_YEL_GRN = 3'd1,
		SECT_GRN_CYN = 3'd2,
		SECT_CYN_BLU = 3'd3,
		SECT_BLU_MAG = 3'd4,
		SECT_MAG_RED = 3'd5
	} sector_t;

	typedef logic [Q_W-1:0] level_t;
	typedef logic [INT_W-1:0] inten_t;

	// Advance enables for the two scaling stages
	typedef struct packed {
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

`default_nettype wire

[hdl/hsva_if.sv]
// Valid/ready channel interfaces: HSV items in, ARGB pixel items out.
// Depends on hsva_pkg for field widths.
`default_nettype none

interface hsva_in_if;
	import hsva_pkg::*;
	logic valid;
	logic ready;
	logic [HUE_W-1:0] hue;
	logic [SAT_W-1:0] saturation;
	logic [VAL_W-1:0] brightness_value;
	logic [INT_W-1:0] intensity;

	modport source (output valid, output hue, output saturation,
		output brightness_value, output intensity, input ready);
	modport sink (input valid, input hue, input saturation,
		input brightness_value, input intensity, output ready);
endinterface

interface hsva_out_if;
	import hsva_pkg::*;
	logic valid;
	logic ready;
	logic [ARGB_W-1:0] argb_word;
	logic clipped;

	modport source (output valid, output argb_word, output clipped, input ready);
	modport sink (input valid, input argb_word, input clipped, output ready);
endinterface

`default_nettype wire

[hdl/hsva_chan.sv]
// One colour channel: scale the clamped level by intensity, then by 255, floor and saturate.
// Pipeline stages 4 and 5 of the converter; depends on hsva_pkg.
`default_nettype none

module hsva_chan import hsva_pkg::*; (
	input  wire logic      clk,
	input  wire stage_en_t en,
	input  wire level_t    level,
	input  wire inten_t    inten,
	output logic [7:0]     chan,
	output logic           clip
);

	logic [P_W-1:0] prod_s4;
	logic [S_W-1:0] scaled;
	logic [HI_W-1:0] whole;

	// Stage 4: level times intensity
	always_ff @(posedge clk) begin
		if (en.s4) begin
			prod_s4 <= P_W'(level) * P_W'(inten);
		end
	end

	// Times 255 as a shift and subtract, keep the integer part
	assign scaled = {prod_s4, 8'b0} - {8'b0, prod_s4};
	assign whole = scaled[S_W-1:SHIFT];

	// Stage 5: saturate at 255 and flag it
	always_ff @(posedge clk) begin
		if (en.s5) begin
			if (whole > HI_W'(CHAN_MAX)) begin
				chan <= CHAN_MAX;
				clip <= 1'b1;
			end else begin
				chan <= whole[7:0];
				clip <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/hsv_to_argb_pixel.sv]
// HSV to packed ARGB pixel converter, top level.
//
// Channel hsv (sink) takes one item per cycle: hue (full circle in 65536 steps),
// saturation and brightness_value in Q1.8, intensity in Q1.8 up to about 2.0.
// Channel pixel (source) gives one item per input item: argb_word with alpha 0xFF
// in bits 31-24 and red, green, blue below, plus clipped when any channel was
// saturated at 255. Negative channel levels clamp to zero without a clip.
//
// Items pass from acceptance to pixel.valid through the five pipeline stages: hue
// sectoring and value * saturation, the chroma ramp product, channel selection,
// the intensity product, and the scale by 255 with saturation. Throughput is one
// item per cycle while pixel.ready is high.
//
// Reset clears all stage valid bits; the pipeline comes up empty and ready.
// When the receiver stalls, the stages behind it keep filling bubbles and then
// hold; hsv.ready falls only once every stage holds an item. Nothing is lost
// or repeated across a stall.
`default_nettype none

module hsv_to_argb_pixel import hsva_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hsva_in_if.sink     hsv,
	hsva_out_if.source  pixel
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	stage_en_t chan_en;

	// Stage 1 signals
	logic [FRAC_W+2:0] hue6;
	sector_t sector;
	logic [FRAC_W-1:0] frac;
	logic [RAMP_W-1:0] ramp;
	sector_t sector_s1;
	logic [RAMP_W-1:0] ramp_s1;
	logic [C16_W-1:0] c16_s1;
	logic [VAL_W-1:0] val_s1;
	inten_t inten_s1;

	// Stage 2 signals
	logic [XX_W-1:0] xx_s2;
	logic signed [MM_W-1:0] mm_s2;
	sector_t sector_s2;
	logic [VAL_W-1:0] val_s2;
	inten_t inten_s2;

	// Stage 3 signals
	logic signed [MM_W-1:0] xm;
	level_t lvl_c, lvl_x, lvl_m;
	level_t q_r, q_g, q_b;
	level_t q_r_s3, q_g_s3, q_b_s3;
	inten_t inten_s3;

	// Stage 5 outputs
	logic [7:0] red, green, blue;
	logic clip_r, clip_g, clip_b;

	// Each stage advances when it is empty or the next one advances
	assign en5 = !v_s5 || pixel.ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign hsv.ready = en1;
	assign chan_en = '{s4: en4, s5: en5};

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= hsv.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Split hue * 6 into sector and fraction; fold the ramp in odd sectors
	assign hue6 = {1'b0, hsv.hue, 2'b00} + {2'b00, hsv.hue, 1'b0};
	assign sector = sector_t'(hue6[FRAC_W+2:FRAC_W]);
	assign frac = hue6[FRAC_W-1:0];
	assign ramp = hue6[FRAC_W] ? (RAMP_W'(1) << FRAC_W) - {1'b0, frac} : {1'b0, frac};

	always_ff @(posedge clk) begin
		if (en1) begin
			sector_s1 <= sector;
			ramp_s1 <= ramp;
			c16_s1 <= C16_W'(hsv.brightness_value) * C16_W'(hsv.saturation);
			val_s1 <= hsv.brightness_value;
			inten_s1 <= hsv.intensity;
		end
	end

	// Stage 2: secondary ramp product and signed offset
	always_ff @(posedge clk) begin
		if (en2) begin
			xx_s2 <= XX_W'(c16_s1) * XX_W'(ramp_s1);
			mm_s2 <= $signed({3'b000, val_s1, 24'b0}) - $signed({2'b00, c16_s1, 16'b0});
			sector_s2 <= sector_s1;
			val_s2 <= val_s1;
			inten_s2 <= inten_s1;
		end
	end

	// Stage 3: levels for chroma, ramp and offset-only channels, clamped at zero
	assign xm = $signed({2'b00, xx_s2}) + mm_s2;
	assign lvl_c = {val_s2, 24'b0};
	assign lvl_m = (mm_s2 > 0) ? mm_s2[Q_W-1:0] : '0;
	assign lvl_x = (xm > 0) ? xm[Q_W-1:0] : '0;

	always_comb begin
		case (sector_s2)
			SECT_RED_YEL: begin q_r = lvl_c; q_g = lvl_x; q_b = lvl_m; end
			SECT_YEL_GRN: begin q_r = lvl_x; q_g = lvl_c; q_b = lvl_m; end
			SECT_GRN_CYN: begin q_r = lvl_m; q_g = lvl_c; q_b = lvl_x; end
			SECT_CYN_BLU: begin q_r = lvl_m; q_g = lvl_x; q_b = lvl_c; end
			SECT_BLU_MAG: begin q_r = lvl_x; q_g = lvl_m; q_b = lvl_c; end
			default: begin q_r = lvl_c; q_g = lvl_m; q_b = lvl_x; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			q_r_s3 <= q_r;
			q_g_s3 <= q_g;
			q_b_s3 <= q_b;
			inten_s3 <= inten_s2;
		end
	end

	// Stages 4 and 5, one scaler per channel
	hsva_chan u_red (
		.clk(clk), .en(chan_en), .level(q_r_s3), .inten(inten_s3),
		.chan(red), .clip(clip_r)
	);
	hsva_chan u_green (
		.clk(clk), .en(chan_en), .level(q_g_s3), .inten(inten_s3),
		.chan(green), .clip(clip_g)
	);
	hsva_chan u_blue (
		.clk(clk), .en(chan_en), .level(q_b_s3), .inten(inten_s3),
		.chan(blue), .clip(clip_b)
	);

	// Pack the pixel
	assign pixel.valid = v_s5;
	assign pixel.argb_word = {ALPHA_BYTE, red, green, blue};
	assign pixel.clipped = clip_r | clip_g | clip_b;

`ifndef SYNTHESIS
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid |-> pixel.argb_word[31:24] == ALPHA_BYTE)
		else $error("alpha byte is not 0xFF");

	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.clipped |-> red == CHAN_MAX || green == CHAN_MAX
			|| blue == CHAN_MAX)
		else $error("clip flagged with no saturated channel");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!hsv.ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !pixel.ready)
		else $error("input stalled while the pipeline has room");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && hsv.ready |=> v_s1)
		else $error("accepted item did not enter stage 1");
`endif

endmodule

`default_nettype wire
